// ----- hw/rtl/hbnt_pkg.sv -----
package hbnt_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int CNT_W         = $clog2(BITS_PER_BYTE);
    localparam int RUN_W         = 3;

    localparam logic [BITS_PER_BYTE-1:0] FLAG_PATTERN = 8'h7E;
    localparam logic [RUN_W-1:0]         STUFF_RUN    = 3'd5;
    localparam logic [CNT_W-1:0]         CNT_LAST     = 3'd7;

    // serializer phases
    typedef enum logic [1:0] {
        S_IDLE,
        S_OPEN,
        S_DATA,
        S_CLOSE
    } t_state;

    // one classified request as it sits in the queue
    typedef struct packed {
        logic                     open_flag;
        logic                     has_byte;
        logic                     close_flag;
        logic [BITS_PER_BYTE-1:0] data;
    } t_entry;

    // one line bit
    typedef struct packed {
        logic line_level;
        logic stuffed_zero;
        logic flag_part;
        logic last_bit;
    } t_line_bit;

endpackage

// ----- hw/rtl/hbnt_if.sv -----
interface hbnt_req_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;
    logic       first_of_frame;
    logic       last_of_frame;

    modport source (
        output valid, cmd, data_byte, first_of_frame, last_of_frame,
        input  ready
    );
    modport sink (
        input  valid, cmd, data_byte, first_of_frame, last_of_frame,
        output ready
    );
endinterface

interface hbnt_bit_if;
    logic valid;
    logic ready;
    logic line_level;
    logic stuffed_zero;
    logic flag_part;
    logic last_bit;

    modport source (
        output valid, line_level, stuffed_zero, flag_part, last_bit,
        input  ready
    );
    modport sink (
        input  valid, line_level, stuffed_zero, flag_part, last_bit,
        output ready
    );
endinterface

// ----- hw/rtl/hdlc_bitsync_nrzi_transmitter_unit.sv -----
// An accepted request goes through the queue and the phase register into the output register.
// One line bit per cycle while the output is not stalled by i_ready; a flag request sends one flag,
//   a byte its data bits plus any stuffed zeros, plus a flag for each opening or closing marker.
// The serializer's single bit path sets the rate; the request queue lets the next
//   request wait while the current one is still shifting out.
// Reset (synchronous, active low): line low, ones run zero, queue and output empty.
module hdlc_bitsync_nrzi_transmitter_unit
    import hbnt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hbnt_req_if.sink   i_req,
    hbnt_bit_if.source o_bit
);

    // front to back queue handshake
    logic      w_q_valid;
    logic      w_q_ready;
    t_entry    w_q_entry;
    t_line_bit w_bit;
    logic      w_bit_valid;

    // Front: takes a request, turns it into open/byte/close markers and
    // queues it so the serializer never has to hold off the source directly.
    hbnt_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_req.valid),
        .o_ready          (i_req.ready),
        .i_cmd            (i_req.cmd),
        .i_data_byte      (i_req.data_byte),
        .i_first_of_frame (i_req.first_of_frame),
        .i_last_of_frame  (i_req.last_of_frame),
        .o_q_valid        (w_q_valid),
        .i_q_ready        (w_q_ready),
        .o_q_entry        (w_q_entry)
    );

    // Back: walks each queued request through opening flag, LSB-first data
    // with zero insertion after five ones, and closing flag. Every bit is
    // NRZI coded (zero toggles the line) and lands in an output register.
    // The next request is pulled on the last bit of the current one, so
    // consecutive requests stream without a gap.
    hbnt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_ready (w_q_ready),
        .i_q_entry (w_q_entry),
        .o_valid   (w_bit_valid),
        .i_ready   (o_bit.ready),
        .o_bit     (w_bit)
    );

    assign o_bit.valid        = w_bit_valid;
    assign o_bit.line_level   = w_bit.line_level;
    assign o_bit.stuffed_zero = w_bit.stuffed_zero;
    assign o_bit.flag_part    = w_bit.flag_part;
    assign o_bit.last_bit     = w_bit.last_bit;

endmodule

// ----- hw/rtl/hbnt_front.sv -----
module hbnt_front
    import hbnt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_cmd,
    input  logic [7:0] i_data_byte,
    input  logic       i_first_of_frame,
    input  logic       i_last_of_frame,
    output logic       o_q_valid,
    input  logic       i_q_ready,
    output t_entry     o_q_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W_Q = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]   PTR_MAX = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W_Q-1:0] Q_FULL  = CNT_W_Q'(QUEUE_DEPTH);

    t_entry               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]     r_wr, n_wr;
    logic [PTR_W-1:0]     r_rd, n_rd;
    logic [CNT_W_Q-1:0]   r_count, n_count;
    t_entry               w_entry;
    logic                 w_push;
    logic                 w_pop;

    // a flag request is an open flag with no byte and no close
    always_comb begin
        if (i_cmd) begin
            w_entry.open_flag  = 1'b1;
            w_entry.has_byte   = 1'b0;
            w_entry.close_flag = 1'b0;
            w_entry.data       = '0;
        end else begin
            w_entry.open_flag  = i_first_of_frame;
            w_entry.has_byte   = 1'b1;
            w_entry.close_flag = i_last_of_frame;
            w_entry.data       = i_data_byte;
        end
    end

    assign o_ready   = (r_count != Q_FULL);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_count != '0);
    assign w_pop     = o_q_valid && i_q_ready;
    assign o_q_entry = r_mem[r_rd];

    always_comb begin
        n_wr    = w_push ? ((r_wr == PTR_MAX) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd    = w_pop  ? ((r_rd == PTR_MAX) ? '0 : r_rd + 1'b1) : r_rd;
        n_count = r_count + CNT_W_Q'(w_push) - CNT_W_Q'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_entry;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_FULL)
        else $error("queue count over depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");

endmodule

// ----- hw/rtl/hbnt_back.sv -----
module hbnt_back
    import hbnt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    output logic      o_q_ready,
    input  t_entry    i_q_entry,
    output logic      o_valid,
    input  logic      i_ready,
    output t_line_bit o_bit
);

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [RUN_W-1:0]         r_run, n_run;
    logic                     r_pend, n_pend;
    logic                     r_tail, n_tail;
    logic                     r_has_byte, n_has_byte;
    logic                     r_close, n_close;
    logic [BITS_PER_BYTE-1:0] r_data, n_data;
    logic                     r_line, n_line;
    logic                     r_out_valid, n_out_valid;
    t_line_bit                r_out, n_out;

    logic             w_step;
    logic             w_bit;
    logic             w_stuffed;
    logic             w_flag;
    logic             w_end_phase;
    logic             w_last;
    logic             w_stuff_req;
    logic [RUN_W-1:0] w_run_inc;
    logic             w_fetch;

    assign w_step    = (r_state != S_IDLE) && (!r_out_valid || i_ready);
    assign w_fetch   = (r_state == S_IDLE) || (w_step && w_last);
    assign o_q_ready = w_fetch;
    assign w_run_inc = r_run + 1'b1;

    // decode of the bit leaving this cycle
    always_comb begin
        w_bit       = 1'b0;
        w_stuffed   = 1'b0;
        w_flag      = 1'b0;
        w_end_phase = 1'b0;
        w_last      = 1'b0;
        w_stuff_req = 1'b0;
        case (r_state)
            S_OPEN: begin
                w_bit       = FLAG_PATTERN[r_cnt];
                w_flag      = 1'b1;
                w_end_phase = (r_cnt == CNT_LAST);
                w_last      = w_end_phase && !r_has_byte;
            end
            S_DATA: begin
                if (r_pend) begin
                    w_stuffed   = 1'b1;
                    w_end_phase = r_tail;
                end else begin
                    w_bit       = r_data[r_cnt];
                    w_stuff_req = w_bit && (w_run_inc == STUFF_RUN);
                    w_end_phase = (r_cnt == CNT_LAST) && !w_stuff_req;
                end
                w_last = w_end_phase && !r_close;
            end
            S_CLOSE: begin
                w_bit       = FLAG_PATTERN[r_cnt];
                w_flag      = 1'b1;
                w_end_phase = (r_cnt == CNT_LAST);
                w_last      = w_end_phase;
            end
            default: ;
        endcase
    end

    // phase sequencing
    always_comb begin
        n_state = r_state;
        if (w_fetch) begin
            if (r_state != S_IDLE || i_q_valid) begin
                if (!i_q_valid) begin
                    n_state = S_IDLE;
                end else if (i_q_entry.open_flag) begin
                    n_state = S_OPEN;
                end else begin
                    n_state = S_DATA;
                end
            end
        end else if (w_step && w_end_phase) begin
            case (r_state)
                S_OPEN:  n_state = S_DATA;
                S_DATA:  n_state = S_CLOSE;
                default: n_state = S_IDLE;
            endcase
        end
    end

    // bit counter, ones run, line level and output register
    always_comb begin
        n_cnt       = r_cnt;
        n_run       = r_run;
        n_pend      = r_pend;
        n_tail      = r_tail;
        n_has_byte  = r_has_byte;
        n_close     = r_close;
        n_data      = r_data;
        n_line      = r_line;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (w_step) begin
            n_line            = w_bit ? r_line : !r_line;
            n_out.line_level  = n_line;
            n_out.stuffed_zero = w_stuffed;
            n_out.flag_part   = w_flag;
            n_out.last_bit    = w_last;
            n_out_valid       = 1'b1;

            if (w_end_phase) begin
                n_cnt = '0;
            end else if (!(r_state == S_DATA && (r_pend || (w_stuff_req && r_cnt == CNT_LAST)))) begin
                n_cnt = r_cnt + 1'b1;
            end

            if (r_state == S_DATA && !r_pend) begin
                n_run  = (w_bit && !w_stuff_req) ? w_run_inc : '0;
                n_pend = w_stuff_req;
                n_tail = (r_cnt == CNT_LAST);
            end else begin
                n_run  = '0;
                n_pend = 1'b0;
            end
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end

        if (w_fetch && i_q_valid) begin
            n_cnt      = '0;
            n_pend     = 1'b0;
            n_tail     = 1'b0;
            n_has_byte = i_q_entry.has_byte;
            n_close    = i_q_entry.close_flag;
            n_data     = i_q_entry.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_run       <= '0;
            r_pend      <= 1'b0;
            r_tail      <= 1'b0;
            r_line      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_run       <= n_run;
            r_pend      <= n_pend;
            r_tail      <= n_tail;
            r_line      <= n_line;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_has_byte <= n_has_byte;
        r_close    <= n_close;
        r_data     <= n_data;
        r_out      <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_bit   = r_out;

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run < STUFF_RUN)
        else $error("ones run reached stuffing length unstuffed");

    a_stuff_not_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.stuffed_zero && r_out.flag_part))
        else $error("stuffed zero inside a flag");

    a_pend_only_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_DATA))
        else $error("stuff pending outside data phase");

    a_line_follows_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_stuffed) |=> (r_line != $past(r_line)))
        else $error("stuffed zero did not toggle the line");

endmodule
